/* rtl/core/rdcc_pkg.sv */
// Package for the remote drive command controller.
// Holds the transaction structs, code constants and lookup tables.
// No dependencies.
`timescale 1ns / 1ps

package rdcc_pkg;

    localparam int RAMP_LENGTH = 20;
    localparam int RAMP_STEP   = 12;

    localparam int POS_W       = $clog2(RAMP_LENGTH + 1);
    localparam int STEPS_W     = 5;
    localparam int STEPS_MAX   = 31;

    localparam int RECIP_SHIFT = 18;
    localparam int RECIP       = (2 ** RECIP_SHIFT + RAMP_STEP - 1) / RAMP_STEP;
    localparam int RECIP_W     = RECIP_SHIFT + 1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_LINK_TIMEOUT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SERVO_HOLD   = 1'd1;

    localparam logic [15:0] LINK_TIMEOUT_RESET = 16'd255;
    localparam logic [15:0] SERVO_HOLD_RESET   = 16'd80;
    localparam logic [15:0] WATCHDOG_RESET     = 16'd255;
    localparam logic [11:0] SERVO_PULSE_RESET  = 12'd1000;

    localparam logic ACT_TICK = 1'b0;
    localparam logic ACT_CMD  = 1'b1;

    localparam logic [1:0] DIR_OFF = 2'd0;
    localparam logic [1:0] DIR_FWD = 2'd1;
    localparam logic [1:0] DIR_REV = 2'd2;

    localparam logic [7:0]  SPEED_MAG [4] = '{8'd0, 8'd50, 8'd70, 8'd127};
    localparam logic [11:0] SERVO_PULSE [4] = '{12'd1000, 12'd1500, 12'd2000, 12'd2500};

    typedef struct packed {
        logic       action;
        logic [7:0] command_byte;
    } t_in_item;

    typedef struct packed {
        logic        left_reverse;
        logic [7:0]  left_duty;
        logic [1:0]  right_direction;
        logic [7:0]  right_duty;
        logic [11:0] servo_pulse;
        logic        servo_power;
    } t_out_item;

    typedef struct packed {
        logic        is_cmd;
        logic [7:0]  left_target;
        logic [7:0]  right_target;
        logic [11:0] pulse;
    } t_op_item;

    typedef struct packed {
        logic [7:0]         speed;
        logic [7:0]         start;
        logic [7:0]         target;
        logic               up;
        logic [STEPS_W-1:0] steps;
        logic [POS_W-1:0]   position;
    } t_ramp;

endpackage

/* rtl/core/remote_drive_command_controller_unit.sv */
// Top level of the remote drive command controller.
// Result path: an accepted transaction is written into the queue, then the back end pops
// it and registers the result; output back-pressure can hold it in the queue.
// Throughput: one transaction per cycle while i_out_ready does not stall the back end.
// Reset: synchronous active-low reset restores control state and configuration to defaults.
// Depends on rdcc_pkg, rdcc_front, rdcc_queue and rdcc_back.
`timescale 1ns / 1ps

module remote_drive_command_controller_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  rdcc_pkg::t_in_item              i_in_item,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output rdcc_pkg::t_out_item             o_out_item,
    input  logic                            i_cfg_wr_en,
    input  logic [rdcc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rdcc_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);

    logic               w_q_full;
    logic               w_q_push;
    logic               w_q_pop;
    logic               w_q_valid;
    rdcc_pkg::t_op_item w_q_wr_item;
    rdcc_pkg::t_op_item w_q_rd_item;

    rdcc_front u_front (
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .i_q_full   (w_q_full),
        .o_q_push   (w_q_push),
        .o_q_item   (w_q_wr_item)
    );

    rdcc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_item  (w_q_wr_item),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_item  (w_q_rd_item)
    );

    rdcc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_valid   (w_q_valid),
        .i_q_item    (w_q_rd_item),
        .o_q_pop     (w_q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

/* rtl/core/rdcc_front.sv */
// Front end of the remote drive command controller.
// Classifies each input transaction and decodes command bytes into targets and a servo pulse.
// Depends on rdcc_pkg.
`timescale 1ns / 1ps

module rdcc_front (
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  rdcc_pkg::t_in_item i_in_item,
    input  logic              i_q_full,
    output logic              o_q_push,
    output rdcc_pkg::t_op_item o_q_item
);

    logic [7:0] w_left_mag;
    logic [7:0] w_right_mag;
    logic [7:0] w_cmd;

    assign w_cmd       = i_in_item.command_byte;
    assign w_left_mag  = rdcc_pkg::SPEED_MAG[w_cmd[1:0]];
    assign w_right_mag = rdcc_pkg::SPEED_MAG[w_cmd[4:3]];

    assign o_in_ready = !i_q_full;
    assign o_q_push   = i_in_valid && !i_q_full;

    always_comb begin
        o_q_item.is_cmd       = (i_in_item.action == rdcc_pkg::ACT_CMD);
        o_q_item.left_target  = w_cmd[2] ? 8'(8'd0 - w_left_mag) : w_left_mag;
        o_q_item.right_target = w_cmd[5] ? 8'(8'd0 - w_right_mag) : w_right_mag;
        o_q_item.pulse        = rdcc_pkg::SERVO_PULSE[w_cmd[7:6]];
    end

endmodule

/* rtl/core/rdcc_queue.sv */
// Short queue between the front end and the back end.
// Register-based FIFO of decoded operations.
// Depends on rdcc_pkg.
`timescale 1ns / 1ps

module rdcc_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  rdcc_pkg::t_op_item i_item,
    output logic               o_full,
    input  logic               i_pop,
    output logic               o_valid,
    output rdcc_pkg::t_op_item o_item
);

    rdcc_pkg::t_op_item r_mem [rdcc_pkg::QUEUE_DEPTH];
    logic [rdcc_pkg::QPTR_W-1:0] r_wr_ptr;
    logic [rdcc_pkg::QPTR_W-1:0] r_rd_ptr;
    logic [rdcc_pkg::QCNT_W-1:0] r_count;
    logic [rdcc_pkg::QPTR_W-1:0] n_wr_ptr;
    logic [rdcc_pkg::QPTR_W-1:0] n_rd_ptr;
    logic [rdcc_pkg::QCNT_W-1:0] n_count;

    localparam logic [rdcc_pkg::QPTR_W-1:0] PTR_LAST = rdcc_pkg::QPTR_W'(rdcc_pkg::QUEUE_DEPTH - 1);
    localparam logic [rdcc_pkg::QCNT_W-1:0] CNT_FULL = rdcc_pkg::QCNT_W'(rdcc_pkg::QUEUE_DEPTH);

    assign o_full  = (r_count == CNT_FULL);
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

/* rtl/core/rdcc_back.sv */
// Back end of the remote drive command controller.
// Holds ramps, timers, servo state and configuration, and registers each result.
// Depends on rdcc_pkg.
`timescale 1ns / 1ps

module rdcc_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [rdcc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [rdcc_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    input  logic                                i_q_valid,
    input  rdcc_pkg::t_op_item                  i_q_item,
    output logic                                o_q_pop,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output rdcc_pkg::t_out_item                 o_out_item
);

    localparam logic [rdcc_pkg::POS_W-1:0] RAMP_END  = rdcc_pkg::POS_W'(rdcc_pkg::RAMP_LENGTH);
    localparam logic [rdcc_pkg::POS_W-1:0] RAMP_LAST = rdcc_pkg::POS_W'(rdcc_pkg::RAMP_LENGTH - 1);

    function automatic rdcc_pkg::t_ramp ramp_advance(input rdcc_pkg::t_ramp m);
        rdcc_pkg::t_ramp r;
        logic [11:0] ofs;
        logic [12:0] base;
        logic [12:0] v;
        r    = m;
        ofs  = 12'(m.position * rdcc_pkg::RAMP_STEP);
        base = {{5{m.start[7]}}, m.start};
        v    = m.up ? base + 13'(ofs) : base - 13'(ofs);
        if (m.position < RAMP_END) begin
            if (m.position == RAMP_LAST) begin
                r.speed = m.target;
            end else if (m.position == '0) begin
                r.speed = m.start;
            end else if (6'(m.position) <= 6'(m.steps)) begin
                r.speed = v[7:0];
            end else begin
                r.speed = m.target;
            end
            r.position = m.position + 1'b1;
        end
        return r;
    endfunction

    function automatic rdcc_pkg::t_ramp ramp_arm(input rdcc_pkg::t_ramp m,
                                                  input logic [7:0] tgt);
        rdcc_pkg::t_ramp r;
        logic signed [8:0] cur;
        logic signed [8:0] tgt9;
        logic [8:0] diff;
        logic [27:0] prod;
        logic [8:0] q;
        logic up;
        cur  = $signed({m.speed[7], m.speed});
        tgt9 = $signed({tgt[7], tgt});
        up   = (tgt9 > cur);
        diff = up ? 9'(tgt9 - cur) : 9'(cur - tgt9);
        prod = 28'(diff) * 28'(rdcc_pkg::RECIP_W'(rdcc_pkg::RECIP));
        q    = 9'(prod >> rdcc_pkg::RECIP_SHIFT);
        r.speed    = m.speed;
        r.start    = m.speed;
        r.target   = tgt;
        r.up       = up;
        r.steps    = (q > 9'(rdcc_pkg::STEPS_MAX)) ? rdcc_pkg::STEPS_W'(rdcc_pkg::STEPS_MAX)
                                                  : q[rdcc_pkg::STEPS_W-1:0];
        r.position = '0;
        return r;
    endfunction

    rdcc_pkg::t_ramp     r_left, n_left;
    rdcc_pkg::t_ramp     r_right, n_right;
    logic [15:0]         r_watchdog, n_watchdog;
    logic [15:0]         r_hold, n_hold;
    logic [11:0]         r_servo_last, n_servo_last;
    logic                r_servo_en, n_servo_en;
    logic [15:0]         r_link_timeout;
    logic [15:0]         r_servo_hold_ticks;
    logic                r_out_valid;
    rdcc_pkg::t_out_item r_out, n_out;
    rdcc_pkg::t_ramp     w_left_adv, w_right_adv;
    logic [15:0]         w_wd_dec, w_hold_dec;
    logic [8:0]          w_left_abs, w_right_abs;
    logic                w_pop;

    assign w_pop       = i_q_valid && (!r_out_valid || i_out_ready);
    assign o_q_pop     = w_pop;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    assign w_left_adv  = ramp_advance(r_left);
    assign w_right_adv = ramp_advance(r_right);
    assign w_wd_dec    = (r_watchdog != '0) ? r_watchdog - 1'b1 : r_watchdog;
    assign w_hold_dec  = (r_hold != '0) ? r_hold - 1'b1 : r_hold;

    always_comb begin
        n_left       = r_left;
        n_right      = r_right;
        n_watchdog   = r_watchdog;
        n_hold       = r_hold;
        n_servo_last = r_servo_last;
        n_servo_en   = r_servo_en;
        if (i_q_item.is_cmd) begin
            n_watchdog = r_link_timeout;
            n_left     = ramp_arm(r_left, i_q_item.left_target);
            n_right    = ramp_arm(r_right, i_q_item.right_target);
            if (i_q_item.pulse != r_servo_last) begin
                n_servo_en   = 1'b1;
                n_hold       = r_servo_hold_ticks;
                n_servo_last = i_q_item.pulse;
            end
        end else begin
            n_hold = w_hold_dec;
            if (w_wd_dec == '0) begin
                n_watchdog = r_link_timeout;
                n_left     = ramp_arm(w_left_adv, 8'd0);
                n_right    = ramp_arm(w_right_adv, 8'd0);
                n_servo_en = 1'b0;
            end else begin
                n_watchdog = w_wd_dec;
                n_left     = w_left_adv;
                n_right    = w_right_adv;
            end
            if (w_hold_dec == '0) begin
                n_servo_en = 1'b0;
            end
        end
    end

    always_comb begin
        w_left_abs  = n_left.speed[7] ? 9'(9'd0 - {1'b1, n_left.speed})
                                      : {1'b0, n_left.speed};
        w_right_abs = n_right.speed[7] ? 9'(9'd0 - {1'b1, n_right.speed})
                                       : {1'b0, n_right.speed};
        n_out.left_reverse = n_left.speed[7];
        n_out.left_duty    = {w_left_abs[6:0], 1'b0};
        if (n_right.speed == '0) begin
            n_out.right_direction = rdcc_pkg::DIR_OFF;
        end else if (n_right.speed[7]) begin
            n_out.right_direction = rdcc_pkg::DIR_REV;
        end else begin
            n_out.right_direction = rdcc_pkg::DIR_FWD;
        end
        n_out.right_duty  = {w_right_abs[6:0], 1'b0};
        n_out.servo_pulse = n_servo_last;
        n_out.servo_power = n_servo_en;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left             <= '{speed: '0, start: '0, target: '0, up: 1'b0,
                                    steps: '0, position: RAMP_END};
            r_right            <= '{speed: '0, start: '0, target: '0, up: 1'b0,
                                    steps: '0, position: RAMP_END};
            r_watchdog         <= rdcc_pkg::WATCHDOG_RESET;
            r_hold             <= '0;
            r_servo_last       <= rdcc_pkg::SERVO_PULSE_RESET;
            r_servo_en         <= 1'b0;
            r_link_timeout     <= rdcc_pkg::LINK_TIMEOUT_RESET;
            r_servo_hold_ticks <= rdcc_pkg::SERVO_HOLD_RESET;
            r_out_valid        <= 1'b0;
        end else begin
            if (w_pop) begin
                r_left       <= n_left;
                r_right      <= n_right;
                r_watchdog   <= n_watchdog;
                r_hold       <= n_hold;
                r_servo_last <= n_servo_last;
                r_servo_en   <= n_servo_en;
                r_out_valid  <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid  <= 1'b0;
            end
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    rdcc_pkg::CFG_LINK_TIMEOUT: r_link_timeout     <= i_cfg_wdata;
                    rdcc_pkg::CFG_SERVO_HOLD:   r_servo_hold_ticks <= i_cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_out <= n_out;
        end
    end

endmodule
